[rtl/core/cses_pkg.sv]
package cses_pkg;

	// Sizes of the matrix and of the entry store.
	localparam int MAX_ROWS    = 256;
	localparam int MAX_COLS    = 256;
	localparam int MAX_ENTRIES = 1024;

	// Field widths of the channels.
	localparam int REG_W    = 9;
	localparam int COORD_W  = 10;
	localparam int VALUE_W  = 32;
	localparam int STATUS_W = 2;

	// Derived widths.
	localparam int COUNT_W  = $clog2(MAX_ENTRIES + 1);
	localparam int ENTRY_AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int COL_W    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
	localparam int RS_DEPTH = MAX_ROWS + 1;
	localparam int RS_AW    = $clog2(RS_DEPTH);
	localparam int BOUND_W  = 14;

	// Operation codes.
	localparam logic OP_READ  = 1'b0;
	localparam logic OP_WRITE = 1'b1;

	// Status codes.
	localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
	localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

	// Configuration register indexes.
	localparam logic CFG_ROWS = 1'b0;
	localparam logic CFG_COLS = 1'b1;

	// One stored element.
	typedef struct packed {
		logic [VALUE_W-1:0] value;
		logic [COL_W-1:0]   column;
	} entry_t;

	// Write port of the entry store.
	typedef struct packed {
		logic                en;
		logic [ENTRY_AW-1:0] addr;
		entry_t              data;
	} entry_wr_t;

	// Write port of the row start store.
	typedef struct packed {
		logic               en;
		logic [RS_AW-1:0]   addr;
		logic [COUNT_W-1:0] data;
	} rs_wr_t;

endpackage

[rtl/core/cses_if.sv]
interface cses_in_if;
	import cses_pkg::*;
	logic                      valid;
	logic                      ready;
	logic                      op;
	logic [COORD_W-1:0]        row;
	logic [COORD_W-1:0]        col;
	logic signed [VALUE_W-1:0] value;

	modport source (output valid, op, row, col, value, input ready);
	modport sink (input valid, op, row, col, value, output ready);
endinterface

interface cses_out_if;
	import cses_pkg::*;
	logic                      valid;
	logic                      ready;
	logic signed [VALUE_W-1:0] read_value;
	logic [STATUS_W-1:0]       status;
	logic [COUNT_W-1:0]        entry_count;

	modport source (output valid, read_value, status, entry_count, input ready);
	modport sink (input valid, read_value, status, entry_count, output ready);
endinterface

interface cses_cfg_if;
	import cses_pkg::*;
	logic             valid;
	logic             ready;
	logic             index;
	logic [REG_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

[rtl/core/csr_sparse_element_store.sv]
// Channel     Dir  Word
// item_in     in   op, row, col, value
// result_out  out  read_value, status, entry_count
// cfg         in   index, data (rows_in_use, cols_in_use)
//
// After reset a clearing pass writes zero to all 257 row starts.
// A lookup reads the row's start and end, then compares the row's entries in column
// order until it meets a column at or above the wanted one or the row's end.
// An insert then shifts the m entries after the insertion point up by one place
// (none when m is zero), places the entry and adds one to the row starts of all
// later rows. Out-of-range items skip the memory and go straight to the result.
// One item is in flight at a time; a result held by a stalled sink holds the next one.
module csr_sparse_element_store
	import cses_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	cses_in_if.sink    item_in,
	cses_out_if.source result_out,
	cses_cfg_if.sink   cfg
);

	localparam logic [3:0] S_CLEAR      = 4'd0;
	localparam logic [3:0] S_IDLE       = 4'd1;
	localparam logic [3:0] S_PTR_A      = 4'd2;
	localparam logic [3:0] S_PTR_B      = 4'd3;
	localparam logic [3:0] S_PTR_C      = 4'd4;
	localparam logic [3:0] S_SCAN_RD    = 4'd5;
	localparam logic [3:0] S_SCAN_CMP   = 4'd6;
	localparam logic [3:0] S_RESOLVE    = 4'd7;
	localparam logic [3:0] S_SHIFT      = 4'd8;
	localparam logic [3:0] S_SHIFT_LAST = 4'd9;
	localparam logic [3:0] S_PLACE      = 4'd10;
	localparam logic [3:0] S_BUMP       = 4'd11;
	localparam logic [3:0] S_BUMP_LAST  = 4'd12;
	localparam logic [3:0] S_DONE       = 4'd13;

	localparam logic [RS_AW-1:0] RS_LAST = RS_AW'(MAX_ROWS);

	logic [3:0]                state_q;
	logic [REG_W-1:0]          rows_in_use_q;
	logic [REG_W-1:0]          cols_in_use_q;
	logic [COUNT_W-1:0]        count_q;

	logic                      op_q;
	logic [RS_AW-1:0]          row_q;
	logic [COL_W-1:0]          col_q;
	logic [VALUE_W-1:0]        value_q;
	logic [COUNT_W-1:0]        idx_q;
	logic [COUNT_W-1:0]        end_q;
	logic                      found_q;
	logic [ENTRY_AW-1:0]       sh_q;
	logic                      pend_q;
	logic [ENTRY_AW-1:0]       sh_wr_addr_q;
	logic [RS_AW-1:0]          r_q;
	logic [RS_AW-1:0]          bump_addr_q;

	logic [VALUE_W-1:0]        res_value_q;
	logic [STATUS_W-1:0]       res_status_q;

	logic                      out_valid_q;
	logic [VALUE_W-1:0]        out_value_q;
	logic [STATUS_W-1:0]       out_status_q;
	logic [COUNT_W-1:0]        out_count_q;

	logic [BOUND_W-1:0]        rows_eff;
	logic [BOUND_W-1:0]        cols_eff;
	logic                      in_range;
	logic                      in_acc;

	logic [ENTRY_AW-1:0]       ent_rd_addr;
	entry_t                    ent_rd;
	entry_wr_t                 ent_wr;
	logic [RS_AW-1:0]          rs_rd_addr;
	logic [COUNT_W-1:0]        rs_rd;
	rs_wr_t                    rs_wr;

	cses_entry_store u_entries (
		.clk     (clk),
		.rd_addr (ent_rd_addr),
		.rd_data (ent_rd),
		.wr      (ent_wr)
	);

	cses_row_start_store u_row_starts (
		.clk     (clk),
		.rd_addr (rs_rd_addr),
		.rd_data (rs_rd),
		.wr      (rs_wr)
	);

	// Handshakes.
	assign item_in.ready = (state_q == S_IDLE);
	assign in_acc        = item_in.valid && item_in.ready;
	assign cfg.ready     = 1'b1;

	assign result_out.valid       = out_valid_q;
	assign result_out.read_value  = out_value_q;
	assign result_out.status      = out_status_q;
	assign result_out.entry_count = out_count_q;

	// Effective bounds: a register above the maximum acts as the maximum.
	always_comb begin
		rows_eff = (BOUND_W'(rows_in_use_q) > BOUND_W'(MAX_ROWS)) ?
			BOUND_W'(MAX_ROWS) : BOUND_W'(rows_in_use_q);
		cols_eff = (BOUND_W'(cols_in_use_q) > BOUND_W'(MAX_COLS)) ?
			BOUND_W'(MAX_COLS) : BOUND_W'(cols_in_use_q);
		in_range = (BOUND_W'(item_in.row) < rows_eff) &&
			(BOUND_W'(item_in.col) < cols_eff);
	end

	// Memory port steering by sequencer state.
	always_comb begin
		ent_rd_addr = idx_q[ENTRY_AW-1:0];
		ent_wr      = '0;
		rs_rd_addr  = row_q;
		rs_wr       = '0;
		unique case (state_q)
			S_CLEAR: begin
				rs_wr.en   = 1'b1;
				rs_wr.addr = r_q;
				rs_wr.data = '0;
			end
			S_PTR_B: begin
				rs_rd_addr = row_q + RS_AW'(1);
			end
			S_RESOLVE: begin
				if (op_q == OP_WRITE && found_q) begin
					ent_wr.en          = 1'b1;
					ent_wr.addr        = idx_q[ENTRY_AW-1:0];
					ent_wr.data.value  = value_q;
					ent_wr.data.column = col_q;
				end
			end
			S_SHIFT, S_SHIFT_LAST: begin
				ent_rd_addr = sh_q;
				ent_wr.en   = pend_q;
				ent_wr.addr = sh_wr_addr_q;
				ent_wr.data = ent_rd;
			end
			S_PLACE: begin
				ent_wr.en          = 1'b1;
				ent_wr.addr        = idx_q[ENTRY_AW-1:0];
				ent_wr.data.value  = value_q;
				ent_wr.data.column = col_q;
			end
			S_BUMP, S_BUMP_LAST: begin
				rs_rd_addr = r_q;
				rs_wr.en   = pend_q;
				rs_wr.addr = bump_addr_q;
				rs_wr.data = rs_rd + COUNT_W'(1);
			end
			default: begin
			end
		endcase
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_in_use_q <= REG_W'(256);
			cols_in_use_q <= REG_W'(256);
		end else if (cfg.valid) begin
			if (cfg.index == CFG_ROWS) begin
				rows_in_use_q <= cfg.data;
			end else begin
				cols_in_use_q <= cfg.data;
			end
		end
	end

	// Sequencer control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			r_q         <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
			pend_q      <= 1'b0;
		end else begin
			// The finishing state decides the output valid on its own.
			if (result_out.ready && state_q != S_DONE) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_CLEAR: begin
					if (r_q == RS_LAST) begin
						state_q <= S_IDLE;
					end else begin
						r_q <= r_q + RS_AW'(1);
					end
				end
				S_IDLE: begin
					if (in_acc) begin
						state_q <= in_range ? S_PTR_A : S_DONE;
					end
				end
				S_PTR_A: state_q <= S_PTR_B;
				S_PTR_B: state_q <= S_PTR_C;
				S_PTR_C: state_q <= S_SCAN_RD;
				S_SCAN_RD: begin
					state_q <= (idx_q == end_q) ? S_RESOLVE : S_SCAN_CMP;
				end
				S_SCAN_CMP: begin
					state_q <= (ent_rd.column >= col_q) ? S_RESOLVE : S_SCAN_RD;
				end
				S_RESOLVE: begin
					pend_q <= 1'b0;
					if (op_q == OP_READ || found_q ||
						count_q == COUNT_W'(MAX_ENTRIES)) begin
						state_q <= S_DONE;
					end else if (count_q == idx_q) begin
						state_q <= S_PLACE;
					end else begin
						state_q <= S_SHIFT;
					end
				end
				S_SHIFT: begin
					pend_q <= 1'b1;
					if (sh_q == idx_q[ENTRY_AW-1:0]) begin
						state_q <= S_SHIFT_LAST;
					end
				end
				S_SHIFT_LAST: state_q <= S_PLACE;
				S_PLACE: begin
					pend_q  <= 1'b0;
					r_q     <= row_q + RS_AW'(1);
					state_q <= S_BUMP;
				end
				S_BUMP: begin
					pend_q <= 1'b1;
					if (r_q == RS_LAST) begin
						state_q <= S_BUMP_LAST;
					end else begin
						r_q <= r_q + RS_AW'(1);
					end
				end
				S_BUMP_LAST: begin
					count_q <= count_q + COUNT_W'(1);
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (!out_valid_q || result_out.ready) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Item payload, scan pointers and result words.
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (in_acc) begin
					op_q    <= item_in.op;
					row_q   <= RS_AW'(item_in.row);
					col_q   <= COL_W'(item_in.col);
					value_q <= item_in.value;
					found_q <= 1'b0;
					res_value_q  <= (item_in.op == OP_READ && !in_range) ? '1 : '0;
					res_status_q <= in_range ? ST_DONE : ST_RANGE;
				end
			end
			S_PTR_B: idx_q <= rs_rd;
			S_PTR_C: end_q <= rs_rd;
			S_SCAN_CMP: begin
				if (ent_rd.column == col_q) begin
					found_q <= 1'b1;
					if (op_q == OP_READ) begin
						res_value_q <= ent_rd.value;
					end
				end else if (ent_rd.column < col_q) begin
					idx_q <= idx_q + COUNT_W'(1);
				end
			end
			S_RESOLVE: begin
				sh_q <= ENTRY_AW'(count_q - COUNT_W'(1));
				if (op_q == OP_WRITE && !found_q && count_q == COUNT_W'(MAX_ENTRIES)) begin
					res_status_q <= ST_FULL;
				end
			end
			S_SHIFT: begin
				sh_wr_addr_q <= sh_q + ENTRY_AW'(1);
				sh_q         <= sh_q - ENTRY_AW'(1);
			end
			S_BUMP: bump_addr_q <= r_q;
			S_DONE: begin
				if (!out_valid_q || result_out.ready) begin
					out_value_q  <= res_value_q;
					out_status_q <= res_status_q;
					out_count_q  <= count_q;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

[rtl/core/cses_entry_store.sv]
module cses_entry_store
	import cses_pkg::*;
(
	input  logic                clk,
	input  logic [ENTRY_AW-1:0] rd_addr,
	output entry_t              rd_data,
	input  entry_wr_t           wr
);

	entry_t mem_q [MAX_ENTRIES];
	entry_t rd_data_q;

	// One write and one registered read each cycle.
	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem_q[wr.addr] <= wr.data;
		end
		rd_data_q <= mem_q[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

[rtl/core/cses_row_start_store.sv]
module cses_row_start_store
	import cses_pkg::*;
(
	input  logic               clk,
	input  logic [RS_AW-1:0]   rd_addr,
	output logic [COUNT_W-1:0] rd_data,
	input  rs_wr_t             wr
);

	logic [COUNT_W-1:0] mem_q [RS_DEPTH];
	logic [COUNT_W-1:0] rd_data_q;

	// One write and one registered read each cycle.
	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem_q[wr.addr] <= wr.data;
		end
		rd_data_q <= mem_q[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

[tb/csr_sparse_element_store_tb.sv]
module csr_sparse_element_store_tb;
	import cses_pkg::*;

	localparam int HALF_PERIOD    = 6;
	localparam int WATCHDOG_LIMIT = 20000;
	localparam int PRINT_CAP      = 40;

	// One result word as the block returns it.
	typedef struct packed {
		logic signed [VALUE_W-1:0] read_value;
		logic [STATUS_W-1:0]       status;
		logic [COUNT_W-1:0]        entry_count;
	} reply_t;

	// One row of the directed table; want is only used when typed is set.
	typedef struct packed {
		logic               op;
		logic [COORD_W-1:0] row;
		logic [COORD_W-1:0] col;
		logic [VALUE_W-1:0] value;
		logic               typed;
		reply_t             want;
	} stim_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	always #HALF_PERIOD clk = ~clk;

	cses_in_if  item_ch();
	cses_out_if reply_ch();
	cses_cfg_if cfg_ch();

	csr_sparse_element_store u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_in    (item_ch),
		.result_out (reply_ch),
		.cfg        (cfg_ch)
	);

	// Shadow copy of the matrix in compressed sparse row form.
	logic [VALUE_W-1:0] elem_value [MAX_ENTRIES];
	logic [COL_W-1:0]   elem_col   [MAX_ENTRIES];
	logic [COUNT_W-1:0] row_first  [RS_DEPTH];
	int                 elem_count;
	logic [REG_W-1:0]   rows_reg;
	logic [REG_W-1:0]   cols_reg;

	reply_t owed_replies[$];
	stim_t  directed_words[$];

	int errors, printed, idle_cycles, items_sent, replies_seen, reg_writes;
	int n_inserts, n_overwrites, n_read_hits, n_range, n_full;
	bit src_idle_on, snk_stall_on;

	task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
		errors++;
		if (printed < PRINT_CAP) begin
			printed++;
			$display("mismatch on reply %0d: %0s got %0h, want %0h",
				replies_seen, what, got, want);
		end
	endtask

	// Index of the row holding stored entry idx.
	function automatic int row_of_entry(int idx);
		int found;
		found = -1;
		for (int r = 0; r < MAX_ROWS; r++) begin
			if (found < 0 && idx < int'(row_first[r+1]))
				found = r;
		end
		return found;
	endfunction

	// Applies one element access to the shadow matrix and returns its reply.
	function automatic reply_t csr_access(logic op, logic [COORD_W-1:0] r,
			logic [COORD_W-1:0] c, logic [VALUE_W-1:0] v);
		reply_t rep;
		int     eff_rows, eff_cols, ri, ci, lo, hi, pos, hit_at;
		rep      = '0;
		eff_rows = (rows_reg > MAX_ROWS) ? MAX_ROWS : int'(rows_reg);
		eff_cols = (cols_reg > MAX_COLS) ? MAX_COLS : int'(cols_reg);
		ri       = int'(r);
		ci       = int'(c);
		if (ri >= eff_rows || ci >= eff_cols) begin
			rep.status = ST_RANGE;
			if (op == OP_READ)
				rep.read_value = '1;
			n_range++;
		end else begin
			lo = (int'(row_first[ri]) > elem_count) ? elem_count : int'(row_first[ri]);
			hi = (int'(row_first[ri+1]) > elem_count) ? elem_count : int'(row_first[ri+1]);
			if (lo > hi)
				lo = hi;
			hit_at = -1;
			for (int i = lo; i < hi; i++) begin
				if (hit_at < 0 && int'(elem_col[i]) == ci)
					hit_at = i;
			end
			if (op == OP_READ) begin
				if (hit_at >= 0) begin
					rep.read_value = elem_value[hit_at];
					n_read_hits++;
				end
			end else if (hit_at >= 0) begin
				elem_value[hit_at] = v;
				n_overwrites++;
			end else if (elem_count >= MAX_ENTRIES) begin
				rep.status = ST_FULL;
				n_full++;
			end else begin
				// New entry goes before the first larger column of its row.
				pos = hi;
				for (int i = hi - 1; i >= lo; i--) begin
					if (int'(elem_col[i]) > ci)
						pos = i;
				end
				for (int i = elem_count; i > pos; i--) begin
					elem_value[i] = elem_value[i-1];
					elem_col[i]   = elem_col[i-1];
				end
				elem_value[pos] = v;
				elem_col[pos]   = c[COL_W-1:0];
				for (int k = ri + 1; k <= MAX_ROWS; k++)
					row_first[k] = row_first[k] + 1'b1;
				elem_count++;
				n_inserts++;
			end
		end
		rep.entry_count = elem_count[COUNT_W-1:0];
		return rep;
	endfunction

	// Offers one word, waits for it to be taken and records the reply it owes.
	task automatic push_item(logic op, logic [COORD_W-1:0] r, logic [COORD_W-1:0] c,
			logic [VALUE_W-1:0] v);
		int gap;
		gap = (src_idle_on && $urandom_range(0, 4) == 0) ? $urandom_range(1, 14) : 0;
		@(negedge clk);
		if (gap > 0) begin
			item_ch.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		item_ch.valid = 1'b1;
		item_ch.op    = op;
		item_ch.row   = r;
		item_ch.col   = c;
		item_ch.value = v;
		do @(posedge clk); while (item_ch.ready !== 1'b1);
		owed_replies.push_back(csr_access(op, r, c, v));
		items_sent++;
	endtask

	// Drops valid and waits until every owed reply has come back.
	task automatic drain_replies();
		@(negedge clk);
		item_ch.valid = 1'b0;
		while (owed_replies.size() != 0) @(posedge clk);
	endtask

	task automatic set_register(logic idx, logic [REG_W-1:0] d);
		@(negedge clk);
		cfg_ch.valid = 1'b1;
		cfg_ch.index = idx;
		cfg_ch.data  = d;
		do @(posedge clk); while (cfg_ch.ready !== 1'b1);
		if (idx == CFG_ROWS)
			rows_reg = d;
		else
			cols_reg = d;
		reg_writes++;
		@(negedge clk);
		cfg_ch.valid = 1'b0;
	endtask

	task automatic configure(int rows, int cols);
		drain_replies();
		set_register(CFG_ROWS, rows[REG_W-1:0]);
		set_register(CFG_COLS, cols[REG_W-1:0]);
	endtask

	// Element values lean towards the extremes now and then.
	function automatic logic [VALUE_W-1:0] pick_value();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return 32'h8000_0000;
			2: return 32'h7FFF_FFFF;
			3: return '1;
			default: return $urandom;
		endcase
	endfunction

	// Mostly accesses to stored or in-bounds elements, with some noise.
	task automatic random_access();
		int                 pick, eff_rows, eff_cols, idx;
		logic               op;
		logic [COORD_W-1:0] r, c;
		eff_rows = (rows_reg > MAX_ROWS) ? MAX_ROWS : int'(rows_reg);
		eff_cols = (cols_reg > MAX_COLS) ? MAX_COLS : int'(cols_reg);
		pick     = $urandom_range(0, 99);
		if (pick < 10) begin
			op = 1'($urandom_range(0, 1));
			r  = COORD_W'($urandom_range(0, 1023));
			c  = COORD_W'($urandom_range(0, 1023));
		end else if (pick < 55 && elem_count > 0) begin
			idx = $urandom_range(0, elem_count - 1);
			r   = COORD_W'(row_of_entry(idx));
			c   = COORD_W'(elem_col[idx]);
			op  = (pick < 45) ? OP_READ : OP_WRITE;
		end else begin
			r  = COORD_W'((eff_rows > 0) ? $urandom_range(0, eff_rows - 1) :
				$urandom_range(0, 1023));
			c  = COORD_W'((eff_cols > 0) ? $urandom_range(0, eff_cols - 1) :
				$urandom_range(0, 1023));
			op = (pick < 70) ? OP_READ : OP_WRITE;
		end
		push_item(op, r, c, pick_value());
	endtask

	task automatic run_phase(int rows, int cols, int n);
		configure(rows, cols);
		src_idle_on  = ($urandom_range(0, 3) != 0);
		snk_stall_on = ($urandom_range(0, 3) != 0);
		repeat (n) random_access();
	endtask

	task automatic add_row(logic op, int r, int c, logic [VALUE_W-1:0] v, int typed,
			logic [VALUE_W-1:0] rv, logic [STATUS_W-1:0] st, int cnt);
		stim_t s;
		s.op                = op;
		s.row               = r[COORD_W-1:0];
		s.col               = c[COORD_W-1:0];
		s.value             = v;
		s.typed             = (typed != 0);
		s.want.read_value   = rv;
		s.want.status       = st;
		s.want.entry_count  = cnt[COUNT_W-1:0];
		directed_words.push_back(s);
	endtask

	// Reply checker: each reply word against the oldest one owed.
	always @(posedge clk) begin : check_replies
		reply_t want;
		if (reply_ch.valid === 1'b1 && reply_ch.ready === 1'b1) begin
			if (owed_replies.size() == 0) begin
				report_mismatch("reply with none owed", 64'd0, 64'd0);
			end else begin
				want = owed_replies.pop_front();
				if (reply_ch.read_value !== want.read_value)
					report_mismatch("read_value", reply_ch.read_value, want.read_value);
				if (reply_ch.status !== want.status)
					report_mismatch("status", reply_ch.status, want.status);
				if (reply_ch.entry_count !== want.entry_count)
					report_mismatch("entry_count", reply_ch.entry_count, want.entry_count);
			end
			replies_seen++;
		end
	end

	// Watchdog: ends the run when no channel has moved a word for too long.
	always @(posedge clk) begin
		if ((item_ch.valid === 1'b1 && item_ch.ready === 1'b1) ||
				(reply_ch.valid === 1'b1 && reply_ch.ready === 1'b1) ||
				(cfg_ch.valid === 1'b1 && cfg_ch.ready === 1'b1))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("timeout: no word moved for %0d cycles, %0d replies still owed",
				WATCHDOG_LIMIT, owed_replies.size());
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// Reply sink with random stall bursts.
	initial begin : reply_sink
		int hold;
		hold           = 0;
		reply_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold > 0) begin
				hold--;
				reply_ch.ready = 1'b0;
			end else if (snk_stall_on && $urandom_range(0, 5) == 0) begin
				hold           = $urandom_range(1, 14) - 1;
				reply_ch.ready = 1'b0;
			end else begin
				reply_ch.ready = 1'b1;
			end
		end
	end

	initial begin : stimulus
		stim_t d;
		item_ch.valid = 1'b0;
		item_ch.op    = OP_READ;
		item_ch.row   = '0;
		item_ch.col   = '0;
		item_ch.value = '0;
		cfg_ch.valid  = 1'b0;
		cfg_ch.index  = CFG_ROWS;
		cfg_ch.data   = '0;
		src_idle_on   = 1'b1;
		snk_stall_on  = 1'b1;
		errors        = 0;
		printed       = 0;
		idle_cycles   = 0;
		elem_count    = 0;
		rows_reg      = REG_W'(MAX_ROWS);
		cols_reg      = REG_W'(MAX_COLS);
		for (int k = 0; k < RS_DEPTH; k++)
			row_first[k] = '0;

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed table: empty store, range errors, extremes, ordered inserts.
		add_row(OP_READ,     0,    0, 32'd0,         1, 32'd0,         ST_DONE,  0);
		add_row(OP_READ,   255,  255, 32'd0,         1, 32'd0,         ST_DONE,  0);
		add_row(OP_READ,   256,    0, 32'd0,         1, 32'hFFFF_FFFF, ST_RANGE, 0);
		add_row(OP_READ,     0,  256, 32'd0,         1, 32'hFFFF_FFFF, ST_RANGE, 0);
		add_row(OP_READ,  1023, 1023, 32'd0,         1, 32'hFFFF_FFFF, ST_RANGE, 0);
		add_row(OP_WRITE, 1023,    0, 32'd5,         1, 32'd0,         ST_RANGE, 0);
		add_row(OP_WRITE,    0, 1023, 32'd7,         1, 32'd0,         ST_RANGE, 0);
		add_row(OP_WRITE,  255,  255, 32'h7FFF_FFFF, 1, 32'd0,         ST_DONE,  1);
		add_row(OP_WRITE,    0,    0, 32'h8000_0000, 1, 32'd0,         ST_DONE,  2);
		add_row(OP_READ,     0,    0, 32'd0,         1, 32'h8000_0000, ST_DONE,  2);
		add_row(OP_READ,   255,  255, 32'h1234_5678, 1, 32'h7FFF_FFFF, ST_DONE,  2);
		add_row(OP_WRITE,    0,    0, 32'd0,         1, 32'd0,         ST_DONE,  2);
		add_row(OP_READ,     0,    0, 32'd0,         1, 32'd0,         ST_DONE,  2);
		add_row(OP_WRITE,    0,  200, 32'hFFFF_FFFF, 1, 32'd0,         ST_DONE,  3);
		add_row(OP_WRITE,    0,  100, 32'd123,       1, 32'd0,         ST_DONE,  4);
		add_row(OP_WRITE,    0,  255, 32'd9,         1, 32'd0,         ST_DONE,  5);
		add_row(OP_READ,     0,  100, 32'd0,         1, 32'd123,       ST_DONE,  5);
		add_row(OP_READ,     0,  200, 32'd0,         1, 32'hFFFF_FFFF, ST_DONE,  5);
		add_row(OP_READ,     0,  150, 32'd0,         1, 32'd0,         ST_DONE,  5);
		add_row(OP_WRITE,  128,    1, 32'hA5A5_A5A5, 0, 32'd0,         ST_DONE,  0);
		add_row(OP_WRITE,  255,    0, 32'h5A5A_5A5A, 0, 32'd0,         ST_DONE,  0);
		add_row(OP_READ,   255,    0, 32'd0,         0, 32'd0,         ST_DONE,  0);
		add_row(OP_READ,   128,    1, 32'd0,         0, 32'd0,         ST_DONE,  0);
		add_row(OP_WRITE,  255,  255, 32'd0,         0, 32'd0,         ST_DONE,  0);
		add_row(OP_READ,     1,    0, 32'd0,         0, 32'd0,         ST_DONE,  0);
		while (directed_words.size() != 0) begin
			d = directed_words.pop_front();
			push_item(d.op, d.row, d.col, d.value);
			if (d.typed)
				owed_replies[owed_replies.size() - 1] = d.want;
		end

		// Random words under a spread of sizes, zero and over-range among them.
		run_phase(1, 1, 25);
		run_phase(0, 256, 15);
		run_phase(256, 0, 15);
		run_phase(511, 511, 60);
		run_phase(257, 300, 40);
		run_phase(5, 17, 40);
		run_phase(256, 1, 25);
		run_phase(1, 256, 25);
		run_phase($urandom_range(1, 256), $urandom_range(1, 256), 40);
		run_phase(256, 256, 40);

		// Fill the entry store to the brim with inserts at random places.
		while (elem_count < MAX_ENTRIES)
			push_item(OP_WRITE, COORD_W'($urandom_range(0, MAX_ROWS - 1)),
				COORD_W'($urandom_range(0, MAX_COLS - 1)), pick_value());

		// Full store, no idling on either side.
		configure(511, 511);
		src_idle_on  = 1'b0;
		snk_stall_on = 1'b0;
		push_item(OP_WRITE, 10'd0, 10'd1, 32'h1111_1111);
		push_item(OP_WRITE, 10'd255, 10'd254, 32'h2222_2222);
		repeat (40) random_access();

		drain_replies();
		repeat (40) @(posedge clk);

		if (owed_replies.size() != 0)
			report_mismatch("replies never returned", 64'd0, 64'(owed_replies.size()));
		$display({"covered %0d words: %0d inserts, %0d overwrites, %0d read hits, ",
			"%0d out of range, %0d refused when full"},
			items_sent, n_inserts, n_overwrites, n_read_hits, n_range, n_full);
		$display("%0d register writes, %0d replies checked, %0d mismatches",
			reg_writes, replies_seen, errors);
		if (errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
